// ===== sv/ppcf_pkg.sv =====
package ppcf_pkg;

  localparam int DIM_W = 13;
  localparam int COLOR_W = 4;
  localparam int NUM_COLORS = 5;
  localparam int HM_W = 2 * (DIM_W - 1);
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int Q_DEPTH = 8;
  localparam int PTR_W = $clog2(Q_DEPTH);
  localparam int CNT_W = $clog2(Q_DEPTH + 1);
  localparam int DEFAULT_MAX_DIMENSION = 4096;

  localparam logic [DIM_W-1:0] WIDTH_RESET = 13'd640;
  localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [COLOR_W-1:0] PAL_LAST = 4'd11;

  typedef enum logic [2:0] {
    OP_PASS,
    OP_PALETTE,
    OP_RED_INV,
    OP_NEGATIVE,
    OP_GRAY
  } op_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic [3:0]                            effect;
    logic [DIM_W-1:0]                      width;
    logic [DIM_W-1:0]                      height;
    logic [NUM_COLORS-1:0][COLOR_W-1:0]    color;
    logic [HM_W-1:0]                       hm;
  } cfg_t;

  typedef struct packed {
    op_t              op;
    logic [COLOR_W-1:0] pal;
    rgb_t             px;
    logic             frame_end;
  } q_entry_t;

  typedef struct packed {
    logic             empty;
    logic [CNT_W-1:0] count;
  } q_status_t;

  function automatic rgb_t palette_color(input logic [COLOR_W-1:0] idx);
    rgb_t c;
    case (idx)
      4'd1:    c = '{8'hff, 8'he4, 8'hb5};
      4'd2:    c = '{8'hcd, 8'h5c, 8'h5c};
      4'd3:    c = '{8'h93, 8'h70, 8'hdb};
      4'd4:    c = '{8'h00, 8'h00, 8'h80};
      4'd5:    c = '{8'hff, 8'h69, 8'hb4};
      4'd6:    c = '{8'h94, 8'h00, 8'hd3};
      4'd7:    c = '{8'h00, 8'hff, 8'hff};
      4'd8:    c = '{8'h5f, 8'h9e, 8'ha0};
      4'd9:    c = '{8'hff, 8'hff, 8'he0};
      4'd10:   c = '{8'hff, 8'h7d, 8'h00};
      4'd11:   c = '{8'hff, 8'h00, 8'h00};
      default: c = '{8'h00, 8'h00, 8'h00};
    endcase
    return c;
  endfunction

endpackage

// ===== sv/positional_pixel_color_filter_core.sv =====
// Positional pixel color filter.
// Input channel: one RGB pixel per beat in raster order, taken when push is
// high and full is low. Row and column counters advance per beat and wrap at
// the configured width and height; out_frame_end marks the last pixel.
// Result channel: the oldest result sits on the out_ ports while empty is
// low and leaves on a beat with pop high.
// Configuration: APB-style port, registers at 4*index, pready tied high.
// Write it only while no pixel is in flight (not enforced by the block).
// Path: a taken pixel passes two front stages, the queue and the output
// register before it shows on the result ports.
// Throughput: one pixel per cycle while pop stays high, limited by the
// single output register and the one-result-per-cycle queue read.
// The front stages never stall; full rises when queue entries plus pixels
// in the front reach the queue depth, so a stalled receiver backs up into
// the 8-entry queue and then holds off push.
// Reset: effect pass, 640x480, all colors zero, position 0,0, queue and
// output empty. No clearing pass is needed.
module positional_pixel_color_filter_core #(
  parameter int MAX_DIMENSION = ppcf_pkg::DEFAULT_MAX_DIMENSION
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_red_in,
  input  logic [7:0]                    in_green_in,
  input  logic [7:0]                    in_blue_in,
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_red_out,
  output logic [7:0]                    out_green_out,
  output logic [7:0]                    out_blue_out,
  output logic                          out_frame_end,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppcf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppcf_pkg::DATA_W-1:0]   pwdata,
  output logic [ppcf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);
  import ppcf_pkg::*;

  localparam int ZW = CNT_W + 1;

  cfg_t      cfg;
  rgb_t      in_px;
  rgb_t      out_px;
  logic      take;
  logic [1:0] in_flight;
  logic      q_wr_en;
  q_entry_t  q_wr_data;
  logic      q_rd_en;
  q_entry_t  q_rd_data;
  q_status_t q_status;
  logic      out_valid;

  assign in_px = '{in_red_in, in_green_in, in_blue_in};
  assign full  = (ZW'(q_status.count) + ZW'(in_flight)) >= ZW'(Q_DEPTH);
  assign take  = push & ~full;

  ppcf_regs #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  ppcf_front #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .in_px     (in_px),
    .cfg       (cfg),
    .in_flight (in_flight),
    .q_wr_en   (q_wr_en),
    .q_wr_data (q_wr_data)
  );

  ppcf_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_wr_en),
    .wr_data (q_wr_data),
    .rd_en   (q_rd_en),
    .rd_data (q_rd_data),
    .status  (q_status)
  );

  ppcf_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_status      (q_status),
    .q_rd_data     (q_rd_data),
    .q_rd_en       (q_rd_en),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_px        (out_px),
    .out_frame_end (out_frame_end)
  );

  assign empty         = ~out_valid;
  assign out_red_out   = out_px.red;
  assign out_green_out = out_px.green;
  assign out_blue_out  = out_px.blue;

endmodule

// ===== sv/ppcf_regs.sv =====
module ppcf_regs #(
  parameter int MAX_DIMENSION = ppcf_pkg::DEFAULT_MAX_DIMENSION
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ppcf_pkg::ADDR_W-1:0]   paddr,
  input  logic [ppcf_pkg::DATA_W-1:0]   pwdata,
  output logic [ppcf_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output ppcf_pkg::cfg_t                cfg
);
  import ppcf_pkg::*;

  typedef enum logic [2:0] {
    REG_EFFECT,
    REG_WIDTH,
    REG_HEIGHT,
    REG_COLOR_ONE,
    REG_COLOR_TWO,
    REG_COLOR_THREE,
    REG_COLOR_FOUR,
    REG_COLOR_FIVE
  } reg_idx_t;

  logic [3:0]         effect_r;
  logic [DIM_W-1:0]   width_r;
  logic [DIM_W-1:0]   height_r;
  logic [COLOR_W-1:0] color_r [NUM_COLORS];
  logic [HM_W-1:0]    hm_r;
  logic [DIM_W-1:0]   width_clamp;
  logic [DIM_W-1:0]   height_clamp;
  logic               wr_en;
  reg_idx_t           idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      effect_r <= '0;
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      for (int i = 0; i < NUM_COLORS; i++) color_r[i] <= '0;
    end else if (wr_en) begin
      unique case (idx)
        REG_EFFECT:      effect_r   <= pwdata[3:0];
        REG_WIDTH:       width_r    <= pwdata[DIM_W-1:0];
        REG_HEIGHT:      height_r   <= pwdata[DIM_W-1:0];
        REG_COLOR_ONE:   color_r[0] <= pwdata[COLOR_W-1:0];
        REG_COLOR_TWO:   color_r[1] <= pwdata[COLOR_W-1:0];
        REG_COLOR_THREE: color_r[2] <= pwdata[COLOR_W-1:0];
        REG_COLOR_FOUR:  color_r[3] <= pwdata[COLOR_W-1:0];
        REG_COLOR_FIVE:  color_r[4] <= pwdata[COLOR_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_EFFECT:      prdata = DATA_W'(effect_r);
      REG_WIDTH:       prdata = DATA_W'(width_r);
      REG_HEIGHT:      prdata = DATA_W'(height_r);
      REG_COLOR_ONE:   prdata = DATA_W'(color_r[0]);
      REG_COLOR_TWO:   prdata = DATA_W'(color_r[1]);
      REG_COLOR_THREE: prdata = DATA_W'(color_r[2]);
      REG_COLOR_FOUR:  prdata = DATA_W'(color_r[3]);
      REG_COLOR_FIVE:  prdata = DATA_W'(color_r[4]);
    endcase
  end

  // zero reads as one, oversize saturates
  always_comb begin
    priority if (width_r == '0) width_clamp = DIM_W'(1);
    else if (int'(width_r) > MAX_DIMENSION) width_clamp = DIM_W'(MAX_DIMENSION);
    else width_clamp = width_r;
    priority if (height_r == '0) height_clamp = DIM_W'(1);
    else if (int'(height_r) > MAX_DIMENSION) height_clamp = DIM_W'(MAX_DIMENSION);
    else height_clamp = height_r;
  end

  // h*m is only needed two stages after accept
  always_ff @(posedge clk) begin
    hm_r <= height_clamp[DIM_W-1:1] * width_clamp[DIM_W-1:1];
  end

  always_comb begin
    cfg.effect = effect_r;
    cfg.width  = width_clamp;
    cfg.height = height_clamp;
    for (int i = 0; i < NUM_COLORS; i++) cfg.color[i] = color_r[i];
    cfg.hm     = hm_r;
  end

endmodule

// ===== sv/ppcf_front.sv =====
module ppcf_front #(
  parameter int MAX_DIMENSION = ppcf_pkg::DEFAULT_MAX_DIMENSION
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  ppcf_pkg::rgb_t       in_px,
  input  ppcf_pkg::cfg_t       cfg,
  output logic [1:0]           in_flight,
  output logic                 q_wr_en,
  output ppcf_pkg::q_entry_t   q_wr_data
);
  import ppcf_pkg::*;

  localparam int PW   = $clog2(MAX_DIMENSION);
  localparam int CW   = ((PW > DIM_W) ? PW : DIM_W) + 1;
  localparam int LW   = CW + 4;
  localparam int SW   = ((PW > DIM_W - 1) ? PW : DIM_W - 1) + 1;
  localparam int SQ_W = 2 * SW;
  localparam int D2_W = SQ_W + 1;
  localparam int RW   = D2_W + 3;

  typedef enum logic [3:0] {
    EFF_PASS,
    EFF_CHECKER,
    EFF_VERT2,
    EFF_VERT3,
    EFF_HORIZ2,
    EFF_HORIZ3,
    EFF_DIAG,
    EFF_RINGS,
    EFF_RED_INV,
    EFF_NEGATIVE,
    EFF_GRAY,
    EFF_RECT_BORDER,
    EFF_RING_BORDER,
    EFF_CORNER_BORDER
  } effect_t;

  typedef enum logic [2:0] {
    SEL_NONE,
    SEL_ONE,
    SEL_TWO,
    SEL_THREE,
    SEL_FOUR,
    SEL_FIVE
  } sel_t;

  effect_t effect;
  assign effect = effect_t'(cfg.effect);

  // position counters and accept stage
  logic [PW-1:0] row_r, col_r;
  logic [CW-1:0] row_inc, col_inc;
  logic          col_wrap, row_wrap;

  logic          s1_v_r;
  rgb_t          s1_px_r;
  logic [PW-1:0] s1_row_r, s1_col_r;
  logic          s1_fe_r;

  assign col_inc  = CW'(col_r) + CW'(1);
  assign row_inc  = CW'(row_r) + CW'(1);
  assign col_wrap = col_inc >= CW'(cfg.width);
  assign row_wrap = row_inc >= CW'(cfg.height);

  // classify stage
  logic            s2_v_r;
  rgb_t            s2_px_r;
  logic            s2_fe_r;
  logic            s2_even_r;
  sel_t            s2_sel_r;
  sel_t            sel_nxt;
  logic [SQ_W-1:0] s2_sqr_r, s2_sqc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r  <= '0;
      col_r  <= '0;
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else begin
      s1_v_r <= take;
      s2_v_r <= s1_v_r;
      if (take) begin
        if (col_wrap) begin
          col_r <= '0;
          row_r <= row_wrap ? '0 : row_inc[PW-1:0];
        end else begin
          col_r <= col_inc[PW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_px_r  <= in_px;
      s1_row_r <= row_r;
      s1_col_r <= col_r;
      s1_fe_r  <= col_wrap & row_wrap;
    end
  end

  logic [LW-1:0]        r, c, c1, wl, hl, ml;
  logic signed [SW-1:0] dr, dc;

  assign r  = LW'(s1_row_r);
  assign c  = LW'(s1_col_r);
  assign c1 = c + LW'(1);
  assign wl = LW'(cfg.width);
  assign hl = LW'(cfg.height);
  assign ml = LW'(cfg.width[DIM_W-1:1]);
  assign dr = $signed(SW'(s1_row_r)) - $signed(SW'(cfg.height[DIM_W-1:1]));
  assign dc = $signed(SW'(s1_col_r)) - $signed(SW'(cfg.width[DIM_W-1:1]));

  // c < floor(W/k) is written as k*(c+1) <= W
  always_comb begin
    sel_nxt = SEL_NONE;
    unique case (effect)
      EFF_CHECKER: sel_nxt = SEL_ONE;
      EFF_VERT2: begin
        priority if (c < ml) sel_nxt = SEL_ONE;
        else if (c > ml) sel_nxt = SEL_TWO;
        else sel_nxt = SEL_NONE;
      end
      EFF_VERT3: begin
        priority if (c1 * LW'(3) <= wl) sel_nxt = SEL_ONE;
        else if (c1 * LW'(3) <= wl * LW'(2)) sel_nxt = SEL_TWO;
        else sel_nxt = SEL_THREE;
      end
      EFF_HORIZ2: begin
        priority if (r * LW'(2) < hl) sel_nxt = SEL_ONE;
        else if (r * LW'(2) > hl) sel_nxt = SEL_TWO;
        else sel_nxt = SEL_NONE;
      end
      EFF_HORIZ3: begin
        priority if (r * LW'(3) < hl) sel_nxt = SEL_ONE;
        else if (r * LW'(3) < hl * LW'(2)) sel_nxt = SEL_TWO;
        else sel_nxt = SEL_THREE;
      end
      EFF_DIAG: begin
        priority if (r < c) sel_nxt = SEL_ONE;
        else if (r > c) sel_nxt = SEL_TWO;
        else sel_nxt = SEL_NONE;
      end
      EFF_RECT_BORDER: begin
        if (r * LW'(10) < hl || r * LW'(10) > hl * LW'(9) ||
            c1 * LW'(10) <= wl || c * LW'(10) > wl * LW'(9)) sel_nxt = SEL_ONE;
      end
      EFF_CORNER_BORDER: begin
        if ((r * LW'(5) < hl || r * LW'(5) > hl * LW'(4)) &&
            (c1 * LW'(5) <= wl || c * LW'(5) > wl * LW'(4))) sel_nxt = SEL_ONE;
      end
      default: sel_nxt = SEL_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (s1_v_r) begin
      s2_px_r   <= s1_px_r;
      s2_fe_r   <= s1_fe_r;
      s2_even_r <= ~s1_row_r[0] & ~s1_col_r[0];
      s2_sel_r  <= sel_nxt;
      s2_sqr_r  <= dr * dr;
      s2_sqc_r  <= dc * dc;
    end
  end

  // ring thresholds and final selection, straight into the queue
  logic [D2_W-1:0]    d2;
  logic [RW-1:0]      d2l, hml;
  sel_t               ring_sel, sel_fin;
  logic [COLOR_W-1:0] idx;

  assign d2  = D2_W'(s2_sqr_r) + D2_W'(s2_sqc_r);
  assign d2l = RW'(d2);
  assign hml = RW'(cfg.hm);

  always_comb begin
    priority if (d2l * RW'(5) <= hml) ring_sel = SEL_ONE;
    else if (d2l * RW'(2) <= hml) ring_sel = SEL_TWO;
    else if (d2l < hml) ring_sel = SEL_THREE;
    else if (d2l < hml * RW'(2)) ring_sel = SEL_FOUR;
    else ring_sel = SEL_FIVE;
  end

  always_comb begin
    priority if (effect == EFF_RINGS) sel_fin = ring_sel;
    else if (effect == EFF_RING_BORDER)
      sel_fin = (d2l * RW'(2) > hml && d2l < hml * RW'(2)) ? SEL_ONE : SEL_NONE;
    else sel_fin = s2_sel_r;
  end

  always_comb begin
    unique case (sel_fin)
      SEL_ONE:   idx = cfg.color[0];
      SEL_TWO:   idx = cfg.color[1];
      SEL_THREE: idx = cfg.color[2];
      SEL_FOUR:  idx = cfg.color[3];
      SEL_FIVE:  idx = cfg.color[4];
      default:   idx = '0;
    endcase
  end

  always_comb begin
    q_wr_data.pal       = idx;
    q_wr_data.px        = s2_px_r;
    q_wr_data.frame_end = s2_fe_r;
    priority if (effect == EFF_RED_INV) q_wr_data.op = OP_RED_INV;
    else if (effect == EFF_NEGATIVE) q_wr_data.op = OP_NEGATIVE;
    else if (effect == EFF_GRAY) q_wr_data.op = OP_GRAY;
    else if (sel_fin != SEL_NONE && s2_even_r && idx != '0 && idx <= PAL_LAST)
      q_wr_data.op = OP_PALETTE;
    else q_wr_data.op = OP_PASS;
  end

  assign q_wr_en   = s2_v_r;
  assign in_flight = 2'(s1_v_r) + 2'(s2_v_r);

endmodule

// ===== sv/ppcf_queue.sv =====
module ppcf_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  ppcf_pkg::q_entry_t   wr_data,
  input  logic                 rd_en,
  output ppcf_pkg::q_entry_t   rd_data,
  output ppcf_pkg::q_status_t  status
);
  import ppcf_pkg::*;

  q_entry_t         mem [Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (wr_en) wr_ptr_r <= wr_ptr_r + PTR_W'(1);
      if (rd_en) rd_ptr_r <= rd_ptr_r + PTR_W'(1);
      unique case ({wr_en, rd_en})
        2'b10:   count_r <= count_r + CNT_W'(1);
        2'b01:   count_r <= count_r - CNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr_r] <= wr_data;
  end

  assign rd_data      = mem[rd_ptr_r];
  assign status.count = count_r;
  assign status.empty = (count_r == '0);

endmodule

// ===== sv/ppcf_back.sv =====
module ppcf_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ppcf_pkg::q_status_t  q_status,
  input  ppcf_pkg::q_entry_t   q_rd_data,
  output logic                 q_rd_en,
  input  logic                 pop,
  output logic                 out_valid,
  output ppcf_pkg::rgb_t       out_px,
  output logic                 out_frame_end
);
  import ppcf_pkg::*;

  // floor(s/3) for s below 768
  localparam logic [16:0] GRAY_RECIP = 17'd43691;

  logic        out_v_r;
  rgb_t        px_r;
  logic        fe_r;
  logic        load;
  rgb_t        pal;
  rgb_t        px_nxt;
  logic [9:0]  sum;
  logic [26:0] prod;
  logic [7:0]  gray;

  assign load    = ~q_status.empty & (~out_v_r | pop);
  assign q_rd_en = load;

  assign pal  = palette_color(q_rd_data.pal);
  assign sum  = 10'(q_rd_data.px.red) + 10'(q_rd_data.px.green) + 10'(q_rd_data.px.blue);
  assign prod = 27'(sum) * 27'(GRAY_RECIP);
  assign gray = prod[24:17];

  always_comb begin
    px_nxt = q_rd_data.px;
    unique case (q_rd_data.op)
      OP_PASS:     px_nxt = q_rd_data.px;
      OP_PALETTE:  px_nxt = pal;
      OP_RED_INV:  px_nxt.red = ~q_rd_data.px.red;
      OP_NEGATIVE: px_nxt = ~q_rd_data.px;
      OP_GRAY:     px_nxt = '{gray, gray, gray};
      default:     px_nxt = q_rd_data.px;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (load) begin
      out_v_r <= 1'b1;
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      px_r <= px_nxt;
      fe_r <= q_rd_data.frame_end;
    end
  end

  assign out_valid     = out_v_r;
  assign out_px        = px_r;
  assign out_frame_end = fe_r;

endmodule

// ===== bench/tb_positional_pixel_color_filter_core.sv =====
module tb_positional_pixel_color_filter_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ppcf_pkg::*;

  localparam int LATENCY = 4;
  localparam int SETTLE_CYCLES = LATENCY + 2;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam longint MAX_DIM = DEFAULT_MAX_DIMENSION;

  // palette entry i sits at bits [24*i +: 24], entry 0 unused
  localparam logic [12*24-1:0] PALETTE = {
    24'hff0000, 24'hff7d00, 24'hffffe0, 24'h5f9ea0, 24'h00ffff, 24'h9400d3,
    24'hff69b4, 24'h000080, 24'h9370db, 24'hcd5c5c, 24'hffe4b5, 24'h000000
  };

  typedef enum logic [3:0] {
    FX_PASS, FX_CHECKER, FX_VBAND2, FX_VBAND3, FX_HBAND2, FX_HBAND3, FX_DIAG,
    FX_RINGS, FX_RED_INV, FX_NEGATIVE, FX_GRAY, FX_BORDER_RECT, FX_BORDER_RING,
    FX_BORDER_CORNER, FX_UNUSED_14, FX_UNUSED_15
  } effect_t;

  typedef enum int {
    REG_EFFECT, REG_WIDTH, REG_HEIGHT, REG_COLOR_ONE, REG_COLOR_TWO,
    REG_COLOR_THREE, REG_COLOR_FOUR, REG_COLOR_FIVE
  } reg_t;

  typedef struct packed {
    rgb_t px;
    logic frame_end;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic [7:0] in_red_in = '0;
  logic [7:0] in_green_in = '0;
  logic [7:0] in_blue_in = '0;
  logic empty;
  logic pop = 1'b0;
  logic [7:0] out_red_out;
  logic [7:0] out_green_out;
  logic [7:0] out_blue_out;
  logic out_frame_end;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;

  // filter state as the bench sees it
  logic [3:0] cfg_effect;
  logic [DIM_W-1:0] cfg_width;
  logic [DIM_W-1:0] cfg_height;
  logic [COLOR_W-1:0] cfg_color [NUM_COLORS];
  logic [11:0] cur_row;
  logic [11:0] cur_col;

  pixel_beat_t awaited_pixels[$];
  int n_errors = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_req = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  positional_pixel_color_filter_core uut (
    .clk(clk), .rst_n(rst_n),
    .push(push), .full(full),
    .in_red_in(in_red_in), .in_green_in(in_green_in), .in_blue_in(in_blue_in),
    .empty(empty), .pop(pop),
    .out_red_out(out_red_out), .out_green_out(out_green_out),
    .out_blue_out(out_blue_out), .out_frame_end(out_frame_end),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint clamp_dim(input logic [DIM_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return longint'(v);
  endfunction

  // palette only lands on even row, even column
  function automatic rgb_t overlay_color(input rgb_t px, input longint r, input longint c,
                                         input logic [COLOR_W-1:0] idx);
    if (idx == 0 || idx > PAL_LAST || r[0] || c[0]) return px;
    return rgb_t'(PALETTE[idx*24 +: 24]);
  endfunction

  function automatic pixel_beat_t filter_pixel(input rgb_t px);
    longint w, ht, r, c, h2, m2, d2, hm;
    logic col_wrap, row_wrap, rows;
    int gray;
    pixel_beat_t beat;
    w = clamp_dim(cfg_width);
    ht = clamp_dim(cfg_height);
    r = longint'(cur_row);
    c = longint'(cur_col);
    h2 = ht / 2;
    m2 = w / 2;
    d2 = (r - h2) * (r - h2) + (c - m2) * (c - m2);
    hm = h2 * m2;
    beat.px = px;
    case (effect_t'(cfg_effect))
      FX_CHECKER: beat.px = overlay_color(px, r, c, cfg_color[0]);
      FX_VBAND2: begin
        if (c < w / 2) beat.px = overlay_color(px, r, c, cfg_color[0]);
        else if (c > w / 2) beat.px = overlay_color(px, r, c, cfg_color[1]);
      end
      FX_VBAND3: begin
        if (c < w / 3) beat.px = overlay_color(px, r, c, cfg_color[0]);
        else if (c < (w * 2) / 3) beat.px = overlay_color(px, r, c, cfg_color[1]);
        else beat.px = overlay_color(px, r, c, cfg_color[2]);
      end
      FX_HBAND2: begin
        if (2 * r < ht) beat.px = overlay_color(px, r, c, cfg_color[0]);
        else if (2 * r > ht) beat.px = overlay_color(px, r, c, cfg_color[1]);
      end
      FX_HBAND3: begin
        if (3 * r < ht) beat.px = overlay_color(px, r, c, cfg_color[0]);
        else if (3 * r < 2 * ht) beat.px = overlay_color(px, r, c, cfg_color[1]);
        else beat.px = overlay_color(px, r, c, cfg_color[2]);
      end
      FX_DIAG: begin
        if (r < c) beat.px = overlay_color(px, r, c, cfg_color[0]);
        else if (r > c) beat.px = overlay_color(px, r, c, cfg_color[1]);
      end
      FX_RINGS: begin
        if (d2 <= hm / 5) beat.px = overlay_color(px, r, c, cfg_color[0]);
        else if (d2 <= hm / 2) beat.px = overlay_color(px, r, c, cfg_color[1]);
        else if (d2 < hm) beat.px = overlay_color(px, r, c, cfg_color[2]);
        else if (d2 < 2 * hm) beat.px = overlay_color(px, r, c, cfg_color[3]);
        else beat.px = overlay_color(px, r, c, cfg_color[4]);
      end
      FX_RED_INV: beat.px.red = 8'hff - px.red;
      FX_NEGATIVE: beat.px = rgb_t'(~px);
      FX_GRAY: begin
        gray = (int'(px.red) + int'(px.green) + int'(px.blue)) / 3;
        beat.px = rgb_t'({gray[7:0], gray[7:0], gray[7:0]});
      end
      FX_BORDER_RECT: begin
        if (10 * r < ht || 10 * r > 9 * ht || c < w / 10 || 10 * c > 9 * w)
          beat.px = overlay_color(px, r, c, cfg_color[0]);
      end
      FX_BORDER_RING: begin
        if (d2 > hm / 2 && d2 < 2 * hm) beat.px = overlay_color(px, r, c, cfg_color[0]);
      end
      FX_BORDER_CORNER: begin
        rows = (5 * r < ht) || (5 * r > 4 * ht);
        if (rows && (c < w / 5 || 5 * c > 4 * w))
          beat.px = overlay_color(px, r, c, cfg_color[0]);
      end
      default: ;
    endcase
    // a position beyond a shrunken size is used as is, then wraps
    col_wrap = (c + 1 >= w);
    row_wrap = (r + 1 >= ht);
    if (col_wrap) begin
      cur_col = '0;
      cur_row = row_wrap ? 12'd0 : 12'(r + 1);
    end else begin
      cur_col = 12'(c + 1);
    end
    beat.frame_end = col_wrap && row_wrap;
    return beat;
  endfunction

  function automatic rgb_t random_pixel();
    return rgb_t'(24'($urandom));
  endfunction

  task automatic write_reg(input reg_t idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_W'(4 * int'(idx));
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    case (idx)
      REG_EFFECT: cfg_effect = value[3:0];
      REG_WIDTH: cfg_width = value[DIM_W-1:0];
      REG_HEIGHT: cfg_height = value[DIM_W-1:0];
      default: cfg_color[int'(idx) - int'(REG_COLOR_ONE)] = value[COLOR_W-1:0];
    endcase
    @(posedge clk);
  endtask

  task automatic send_pixel(input rgb_t px);
    while ($urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_red_in <= px.red;
    in_green_in <= px.green;
    in_blue_in <= px.blue;
    do @(posedge clk); while (full);
    awaited_pixels.push_back(filter_pixel(px));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (awaited_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic check_pixel();
    pixel_beat_t want;
    if (awaited_pixels.size() == 0) begin
      $error("unexpected beat: rgb %02h %02h %02h frame_end %0b",
             out_red_out, out_green_out, out_blue_out, out_frame_end);
      n_errors++;
    end else begin
      want = awaited_pixels.pop_front();
      if (out_red_out !== want.px.red) begin
        $error("red_out: expected %0d, got %0d", want.px.red, out_red_out);
        n_errors++;
      end
      if (out_green_out !== want.px.green) begin
        $error("green_out: expected %0d, got %0d", want.px.green, out_green_out);
        n_errors++;
      end
      if (out_blue_out !== want.px.blue) begin
        $error("blue_out: expected %0d, got %0d", want.px.blue, out_blue_out);
        n_errors++;
      end
      if (out_frame_end !== want.frame_end) begin
        $error("frame_end: expected %0b, got %0b", want.frame_end, out_frame_end);
        n_errors++;
      end
    end
  endtask

  // result side: random stalls plus an occasional long hold-off
  always @(posedge clk) begin
    if (rst_n && pop && !empty) check_pixel();
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (push && !full) || (pop && !empty)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_dimension();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1;
      2: return MAX_DIM;
      3: return 8191;
      4: return $urandom_range(0, 8191);
      default: return $urandom_range(1, 14);
    endcase
  endfunction

  function automatic logic [31:0] pick_color();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 11);
    return $urandom_range(0, 15);
  endfunction

  task automatic randomize_setup();
    write_reg(REG_EFFECT, $urandom_range(0, 15));
    write_reg(REG_WIDTH, pick_dimension());
    write_reg(REG_HEIGHT, pick_dimension());
    write_reg(REG_COLOR_ONE, pick_color());
    write_reg(REG_COLOR_TWO, pick_color());
    write_reg(REG_COLOR_THREE, pick_color());
    write_reg(REG_COLOR_FOUR, pick_color());
    write_reg(REG_COLOR_FIVE, pick_color());
  endtask

  // single-pixel frame pins the position at 0,0 while each effect code is tried
  task automatic test_effect_sweep();
    write_reg(REG_WIDTH, 1);
    write_reg(REG_HEIGHT, 1);
    write_reg(REG_COLOR_ONE, 1);
    write_reg(REG_COLOR_TWO, 5);
    write_reg(REG_COLOR_THREE, 9);
    write_reg(REG_COLOR_FOUR, 11);
    write_reg(REG_COLOR_FIVE, 15);
    for (int fx = 0; fx < 16; fx++) begin
      write_reg(REG_EFFECT, fx);
      case (fx % 3)
        0: send_pixel(rgb_t'(24'hffffff));
        1: send_pixel(rgb_t'(24'h000000));
        default: send_pixel(rgb_t'(24'hff0081));
      endcase
      wait_drained();
    end
  endtask

  // index zero and indices above the palette leave the pixel alone
  task automatic test_palette_index_limits();
    write_reg(REG_EFFECT, FX_CHECKER);
    write_reg(REG_COLOR_ONE, 0);
    send_pixel(random_pixel());
    wait_drained();
    write_reg(REG_COLOR_ONE, 12);
    send_pixel(random_pixel());
    wait_drained();
    write_reg(REG_COLOR_ONE, 15);
    send_pixel(random_pixel());
    wait_drained();
  endtask

  task automatic test_dimension_limits();
    write_reg(REG_EFFECT, FX_BORDER_RECT);
    write_reg(REG_COLOR_ONE, 7);
    write_reg(REG_WIDTH, 0);
    write_reg(REG_HEIGHT, 8191);
    send_pixel(random_pixel());
    send_pixel(random_pixel());
    wait_drained();
    write_reg(REG_EFFECT, FX_RINGS);
    write_reg(REG_WIDTH, MAX_DIM);
    write_reg(REG_HEIGHT, 0);
    send_pixel(random_pixel());
    wait_drained();
  endtask

  task automatic test_midframe_resize();
    write_reg(REG_EFFECT, FX_DIAG);
    write_reg(REG_COLOR_ONE, 2);
    write_reg(REG_COLOR_TWO, 3);
    write_reg(REG_WIDTH, 8);
    write_reg(REG_HEIGHT, 2);
    repeat (3) send_pixel(random_pixel());
    wait_drained();
    // column now past the new width
    write_reg(REG_WIDTH, 2);
    repeat (3) send_pixel(random_pixel());
    wait_drained();
  endtask

  task automatic test_backpressure();
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    write_reg(REG_EFFECT, FX_NEGATIVE);
    write_reg(REG_WIDTH, 5);
    write_reg(REG_HEIGHT, 3);
    hold_req++;
    repeat (40) send_pixel(random_pixel());
    wait_drained();
    repeat (10) send_pixel(random_pixel());
    wait_drained();
  endtask

  task automatic test_random_traffic();
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin tx_idle_pct = 0; rx_stall_pct = 0; end
        1: begin tx_idle_pct = 66; rx_stall_pct = 0; end
        2: begin tx_idle_pct = 0; rx_stall_pct = 66; end
        default: begin tx_idle_pct = 7; rx_stall_pct = 7; end
      endcase
      repeat (4) begin
        randomize_setup();
        repeat (20) send_pixel(random_pixel());
        wait_drained();
      end
    end
  endtask

  initial begin
    cfg_effect = FX_PASS;
    cfg_width = WIDTH_RESET;
    cfg_height = HEIGHT_RESET;
    foreach (cfg_color[i]) cfg_color[i] = '0;
    cur_row = '0;
    cur_col = '0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_effect_sweep();
    test_palette_index_limits();
    test_dimension_limits();
    test_midframe_resize();
    test_backpressure();
    test_random_traffic();
    if (n_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
